// ===== src/cva_pkg.sv =====
package cva_pkg;

  localparam int DataWidth = 16;
  localparam int AccWidth  = 48;

  typedef enum logic [1:0] {
    MODE_DOT   = 2'd0,
    MODE_NORM  = 2'd1,
    MODE_AXPY  = 2'd2,
    MODE_SCALE = 2'd3
  } mode_e;

  localparam logic [1:0] CFG_SCALAR_RE    = 2'd0;
  localparam logic [1:0] CFG_SCALAR_IM    = 2'd1;
  localparam logic [1:0] CFG_SCALE_FACTOR = 2'd2;

  localparam logic signed [DataWidth-1:0] ScaleReset = {1'b0, {(DataWidth-1){1'b1}}};

  typedef struct packed {
    mode_e                        mode;
    logic signed [DataWidth-1:0]  v_re;
    logic signed [DataWidth-1:0]  v_im;
    logic signed [DataWidth-1:0]  w_re;
    logic signed [DataWidth-1:0]  w_im;
    logic                         last;
  } item_t;

  typedef struct packed {
    logic signed [AccWidth-1:0]   out_re;
    logic signed [AccWidth-1:0]   out_im;
    logic                         is_sum;
    logic                         saturated;
  } result_t;

  typedef struct packed {
    logic signed [DataWidth-1:0]  scalar_re;
    logic signed [DataWidth-1:0]  scalar_im;
    logic signed [DataWidth-1:0]  scale_factor;
  } cfg_t;

  typedef struct packed {
    logic signed [AccWidth-1:0]   acc_re;
    logic signed [AccWidth-1:0]   acc_im;
    logic                         sat_seen;
  } acc_t;

endpackage

// ===== src/cva_math.sv =====
module cva_math (
  input  cva_pkg::item_t   item_i,
  input  cva_pkg::cfg_t    cfg_i,
  input  cva_pkg::acc_t    acc_i,
  output cva_pkg::acc_t    acc_o,
  output cva_pkg::result_t res_o,
  output logic             res_valid_o
);

  localparam int DW     = cva_pkg::DataWidth;
  localparam int AW     = cva_pkg::AccWidth;
  localparam int ProdW  = 2 * DW;
  localparam int PW     = ProdW + 2;
  localparam int EW     = PW - (DW - 1) + 1;
  localparam int SumW   = AW + 2;
  localparam logic [PW-1:0] Half = PW'(1) << (DW - 2);

  logic signed [DW-1:0]    a0, b0, a1, b1, a2, b2, a3, b3;
  logic signed [ProdW-1:0] m0, m1, m2, m3;
  logic signed [PW-1:0]    prod_re, prod_im, rnd_re, rnd_im;
  logic signed [EW-1:0]    base_re, base_im, el_re, el_im;
  logic signed [DW-1:0]    el_re_sat, el_im_sat;
  logic                    el_clip_re, el_clip_im;
  logic signed [SumW-1:0]  sum_re, sum_im;
  logic signed [AW-1:0]    sum_re_sat, sum_im_sat;
  logic                    acc_clip_re, acc_clip_im;
  logic                    is_acc_mode, is_dot, clip_any;

  // Four shared multipliers; operand selection depends on the mode.
  always_comb begin
    a0 = item_i.v_re; b0 = item_i.w_re;
    a1 = item_i.v_im; b1 = item_i.w_im;
    a2 = item_i.v_re; b2 = item_i.w_im;
    a3 = item_i.v_im; b3 = item_i.w_re;
    case (item_i.mode)
      cva_pkg::MODE_DOT: begin
      end
      cva_pkg::MODE_NORM: begin
        b0 = item_i.v_re;
        b1 = item_i.v_im;
      end
      cva_pkg::MODE_AXPY: begin
        a0 = cfg_i.scalar_re;
        a1 = cfg_i.scalar_im;
        a2 = cfg_i.scalar_re;
        a3 = cfg_i.scalar_im;
      end
      default: begin
        a0 = cfg_i.scale_factor; b0 = item_i.v_re;
        a1 = cfg_i.scale_factor; b1 = item_i.v_im;
      end
    endcase
  end

  assign m0 = a0 * b0;
  assign m1 = a1 * b1;
  assign m2 = a2 * b2;
  assign m3 = a3 * b3;

  // Accumulator path: exact three-way sum, clipped once.
  assign is_dot      = (item_i.mode == cva_pkg::MODE_DOT);
  assign is_acc_mode = is_dot || (item_i.mode == cva_pkg::MODE_NORM);
  assign sum_re = SumW'(acc_i.acc_re) + SumW'(m0) + SumW'(m1);
  assign sum_im = SumW'(acc_i.acc_im) + SumW'(m2) - SumW'(m3);

  assign acc_clip_re = !((&sum_re[SumW-1:AW-1]) || !(|sum_re[SumW-1:AW-1]));
  assign acc_clip_im = is_dot && !((&sum_im[SumW-1:AW-1]) || !(|sum_im[SumW-1:AW-1]));

  assign sum_re_sat = acc_clip_re ? {sum_re[SumW-1], {(AW-1){!sum_re[SumW-1]}}}
                                  : sum_re[AW-1:0];
  assign sum_im_sat = acc_clip_im ? {sum_im[SumW-1], {(AW-1){!sum_im[SumW-1]}}}
                                  : sum_im[AW-1:0];

  // Element path: round the Q2.30 product half up, add the base, clip.
  always_comb begin
    if (item_i.mode == cva_pkg::MODE_AXPY) begin
      prod_re = PW'(m0) - PW'(m1);
      prod_im = PW'(m2) + PW'(m3);
      base_re = EW'(item_i.v_re);
      base_im = EW'(item_i.v_im);
    end else begin
      prod_re = PW'(m0);
      prod_im = PW'(m1);
      base_re = '0;
      base_im = '0;
    end
  end

  assign rnd_re = (prod_re + $signed(Half)) >>> (DW - 1);
  assign rnd_im = (prod_im + $signed(Half)) >>> (DW - 1);
  assign el_re  = EW'(rnd_re) + base_re;
  assign el_im  = EW'(rnd_im) + base_im;

  assign el_clip_re = !((&el_re[EW-1:DW-1]) || !(|el_re[EW-1:DW-1]));
  assign el_clip_im = !((&el_im[EW-1:DW-1]) || !(|el_im[EW-1:DW-1]));
  assign el_re_sat  = el_clip_re ? {el_re[EW-1], {(DW-1){!el_re[EW-1]}}} : el_re[DW-1:0];
  assign el_im_sat  = el_clip_im ? {el_im[EW-1], {(DW-1){!el_im[EW-1]}}} : el_im[DW-1:0];

  assign clip_any = acc_clip_re || acc_clip_im || acc_i.sat_seen;

  always_comb begin
    acc_o       = acc_i;
    res_o       = '0;
    res_valid_o = 1'b0;
    if (is_acc_mode) begin
      acc_o.acc_re   = sum_re_sat;
      acc_o.acc_im   = is_dot ? sum_im_sat : acc_i.acc_im;
      acc_o.sat_seen = clip_any;
      if (item_i.last) begin
        res_valid_o     = 1'b1;
        res_o.out_re    = acc_o.acc_re;
        res_o.out_im    = acc_o.acc_im;
        res_o.is_sum    = 1'b1;
        res_o.saturated = clip_any;
        acc_o           = '0;
      end
    end else begin
      res_valid_o     = 1'b1;
      res_o.out_re    = AW'(el_re_sat);
      res_o.out_im    = AW'(el_im_sat);
      res_o.is_sum    = 1'b0;
      res_o.saturated = el_clip_re || el_clip_im;
    end
  end

endmodule

// ===== src/complex_vector_alu_unit.sv =====
// Complex vector ALU: conjugated dot product, squared norm, v+z*w and r*v.
// Items are registered in stage 1 and their results in the output register.
// One item per cycle unless the output stalls; one accumulator add per cycle.
// Reset clears the pipeline and the accumulators and loads the register
// defaults (z = 0, r = largest positive Q1.15 value).
module complex_vector_alu_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cva_pkg::item_t                 in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cva_pkg::result_t               out_item_o,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [cva_pkg::DataWidth-1:0]  cfg_data_i
);

  logic             s1_valid_q;
  cva_pkg::item_t   s1_item_q;
  logic             out_valid_q;
  cva_pkg::result_t out_item_q;
  cva_pkg::acc_t    acc_q, acc_d;
  cva_pkg::cfg_t    cfg_q;
  cva_pkg::result_t res;
  logic             res_valid;
  logic             advance, fire;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign fire       = s1_valid_q && advance;

  cva_math u_math (
    .item_i      (s1_item_q),
    .cfg_i       (cfg_q),
    .acc_i       (acc_q),
    .acc_o       (acc_d),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= fire && res_valid;
      end
      if (fire) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scalar_re    <= '0;
      cfg_q.scalar_im    <= '0;
      cfg_q.scale_factor <= cva_pkg::ScaleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cva_pkg::CFG_SCALAR_RE:    cfg_q.scalar_re    <= cfg_data_i;
        cva_pkg::CFG_SCALAR_IM:    cfg_q.scalar_im    <= cfg_data_i;
        cva_pkg::CFG_SCALE_FACTOR: cfg_q.scale_factor <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== verif/complex_vector_alu_unit_tb.sv =====
module complex_vector_alu_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     AccWidth  = cva_pkg::AccWidth;
  localparam int     DataWidth = cva_pkg::DataWidth;
  localparam longint AccMax    = (longint'(1) <<< (AccWidth - 1)) - 1;
  localparam longint AccMin    = -AccMax - 1;
  localparam longint ElemMax   = (longint'(1) <<< (DataWidth - 1)) - 1;
  localparam longint ElemMin   = -ElemMax - 1;
  localparam longint RoundHalf = longint'(1) <<< (DataWidth - 2);
  localparam int     LongRun   = 30;

  // Tracks the register file and the accumulators, and holds the results
  // that the block still owes.
  class vec_result_tracker;
    cva_pkg::cfg_t    regs;
    longint           acc_re;
    longint           acc_im;
    bit               acc_clipped;
    cva_pkg::result_t owed_results[$];
    int               n_items;
    int               n_results;
    int               n_sums;
    int               n_clipped;
    int               n_errors;

    function new();
      regs.scalar_re    = '0;
      regs.scalar_im    = '0;
      regs.scale_factor = cva_pkg::ScaleReset;
      acc_re      = 0;
      acc_im      = 0;
      acc_clipped = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [DataWidth-1:0] data);
      case (idx)
        cva_pkg::CFG_SCALAR_RE:    regs.scalar_re = data;
        cva_pkg::CFG_SCALAR_IM:    regs.scalar_im = data;
        cva_pkg::CFG_SCALE_FACTOR: regs.scale_factor = data;
        default: ;
      endcase
    endfunction

    function longint clip_acc(longint s, inout bit clip);
      if (s > AccMax) begin
        clip = 1'b1;
        return AccMax;
      end
      if (s < AccMin) begin
        clip = 1'b1;
        return AccMin;
      end
      return s;
    endfunction

    // Rounds a Q2.30 product half up to Q1.15, adds the base, then clips.
    function longint round_elem(longint base, longint prod, inout bit clip);
      longint r;
      r = ((prod + RoundHalf) >>> (DataWidth - 1)) + base;
      if (r > ElemMax) begin
        clip = 1'b1;
        return ElemMax;
      end
      if (r < ElemMin) begin
        clip = 1'b1;
        return ElemMin;
      end
      return r;
    endfunction

    function void apply_element(cva_pkg::item_t it);
      longint           vr, vi, wr, wi, zr, zi, rf;
      bit               clip;
      cva_pkg::result_t res;
      vr = $signed(it.v_re);
      vi = $signed(it.v_im);
      wr = $signed(it.w_re);
      wi = $signed(it.w_im);
      zr = $signed(regs.scalar_re);
      zi = $signed(regs.scalar_im);
      rf = $signed(regs.scale_factor);
      clip = 1'b0;
      n_items++;
      case (it.mode)
        cva_pkg::MODE_DOT, cva_pkg::MODE_NORM: begin
          if (it.mode == cva_pkg::MODE_DOT) begin
            acc_re = clip_acc(acc_re + vr * wr + vi * wi, clip);
            acc_im = clip_acc(acc_im + vr * wi - vi * wr, clip);
          end else begin
            acc_re = clip_acc(acc_re + vr * vr + vi * vi, clip);
          end
          acc_clipped |= clip;
          if (it.last) begin
            res.out_re    = AccWidth'(acc_re);
            res.out_im    = AccWidth'(acc_im);
            res.is_sum    = 1'b1;
            res.saturated = acc_clipped;
            owed_results.push_back(res);
            acc_re      = 0;
            acc_im      = 0;
            acc_clipped = 1'b0;
          end
        end
        cva_pkg::MODE_AXPY: begin
          res.out_re    = AccWidth'(round_elem(vr, zr * wr - zi * wi, clip));
          res.out_im    = AccWidth'(round_elem(vi, zr * wi + zi * wr, clip));
          res.is_sum    = 1'b0;
          res.saturated = clip;
          owed_results.push_back(res);
        end
        default: begin
          res.out_re    = AccWidth'(round_elem(0, rf * vr, clip));
          res.out_im    = AccWidth'(round_elem(0, rf * vi, clip));
          res.is_sum    = 1'b0;
          res.saturated = clip;
          owed_results.push_back(res);
        end
      endcase
    endfunction

    function bit field_ok(string name, logic [AccWidth-1:0] want,
                          logic [AccWidth-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void compare_result(cva_pkg::result_t got);
      cva_pkg::result_t want;
      bit               ok;
      if (owed_results.size() == 0) begin
        $display("%0t: result with none pending, got %p", $time, got);
        n_errors++;
        return;
      end
      want = owed_results.pop_front();
      n_results++;
      if (want.is_sum) n_sums++;
      if (want.saturated) n_clipped++;
      ok = field_ok("out_re", want.out_re, got.out_re);
      ok = field_ok("out_im", want.out_im, got.out_im) && ok;
      ok = field_ok("is_sum", want.is_sum, got.is_sum) && ok;
      ok = field_ok("saturated", want.saturated, got.saturated) && ok;
      if (!ok) n_errors++;
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  cva_pkg::item_t       in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  cva_pkg::result_t     out_item;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_idx = '0;
  logic [DataWidth-1:0] cfg_data = '0;

  int send_idle_pct = 19;
  int recv_idle_pct = 48;

  vec_result_tracker tracker = new();

  complex_vector_alu_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("Timeout: items or results stopped moving");
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off once traffic is flowing so
  // that the block backs up into its input.
  initial begin : rx_side
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && tracker.n_results >= 60) begin
        held = 1'b1;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && out_ready) tracker.compare_result(out_item);
  end

  function automatic cva_pkg::item_t mk(cva_pkg::mode_e mode, int vr, int vi, int wr,
                                        int wi, bit last);
    cva_pkg::item_t it;
    it.mode = mode;
    it.v_re = DataWidth'(vr);
    it.v_im = DataWidth'(vi);
    it.w_re = DataWidth'(wr);
    it.w_im = DataWidth'(wi);
    it.last = last;
    return it;
  endfunction

  function automatic logic [DataWidth-1:0] rand_comp();
    case ($urandom_range(15))
      0:       return {1'b1, {(DataWidth-1){1'b0}}};
      1:       return {1'b0, {(DataWidth-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return DataWidth'($urandom);
    endcase
  endfunction

  function automatic cva_pkg::item_t rand_elem(cva_pkg::mode_e mode, bit last);
    cva_pkg::item_t it;
    it.mode = mode;
    it.v_re = rand_comp();
    it.v_im = rand_comp();
    it.w_re = rand_comp();
    it.w_im = rand_comp();
    it.last = last;
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(cva_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (!in_ready);
    tracker.apply_element(it);
    @(negedge clk_i);
  endtask

  // Lowers valid and waits until every owed result is back and the pipeline
  // has had time to finish items that produce none.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.owed_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_regs(int zr, int zi, int rf);
    cfg_we   <= 1'b1;
    cfg_idx  <= cva_pkg::CFG_SCALAR_RE;
    cfg_data <= DataWidth'(zr);
    @(posedge clk_i);
    tracker.write_reg(cva_pkg::CFG_SCALAR_RE, DataWidth'(zr));
    @(negedge clk_i);
    cfg_idx  <= cva_pkg::CFG_SCALAR_IM;
    cfg_data <= DataWidth'(zi);
    @(posedge clk_i);
    tracker.write_reg(cva_pkg::CFG_SCALAR_IM, DataWidth'(zi));
    @(negedge clk_i);
    cfg_idx  <= cva_pkg::CFG_SCALE_FACTOR;
    cfg_data <= DataWidth'(rf);
    @(posedge clk_i);
    tracker.write_reg(cva_pkg::CFG_SCALE_FACTOR, DataWidth'(rf));
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly well-formed vectors ended by last, with some mode mixing and early
  // ends mixed in; element modes carry random last bits.
  task automatic send_random(int count);
    int             sent;
    int             len;
    cva_pkg::mode_e mode;
    cva_pkg::item_t it;
    sent = 0;
    while (sent < count) begin
      mode = cva_pkg::mode_e'($urandom_range(3));
      if (mode == cva_pkg::MODE_DOT || mode == cva_pkg::MODE_NORM) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          it = rand_elem(mode, k == len - 1);
          if ($urandom_range(9) == 0) it.mode = cva_pkg::mode_e'($urandom_range(3));
          if ($urandom_range(19) == 0) it.last = 1'b1;
          send_item(it);
          sent++;
        end
      end else begin
        send_item(rand_elem(mode, 1'($urandom_range(1))));
        sent++;
      end
    end
  endtask

  task automatic send_long(cva_pkg::mode_e mode, int vr, int vi, int wr, int wi);
    for (int k = 0; k < LongRun; k++) send_item(mk(mode, vr, vi, wr, wi, k == LongRun - 1));
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset register values: z = 0, r = largest positive.
    send_item(mk(cva_pkg::MODE_SCALE, 32767, -32768, 0, 0, 1'b1));
    send_item(mk(cva_pkg::MODE_AXPY, -32768, 32767, 32767, -32768, 1'b0));
    // A last on the very first element emits that element's sum alone.
    send_item(mk(cva_pkg::MODE_DOT, -32768, -32768, 32767, -32768, 1'b1));
    send_item(mk(cva_pkg::MODE_NORM, 32767, -32768, 0, 0, 1'b0));
    send_item(mk(cva_pkg::MODE_NORM, -1, 1, 0, 0, 1'b1));
    // Dot and norm terms share the accumulator; the element item in between
    // leaves it alone and its last bit does nothing.
    send_item(mk(cva_pkg::MODE_DOT, 12345, -2222, -32768, 32767, 1'b0));
    send_item(mk(cva_pkg::MODE_AXPY, 100, -100, 5, 5, 1'b1));
    send_item(mk(cva_pkg::MODE_NORM, -32768, 32767, 0, 0, 1'b1));
    send_item(mk(cva_pkg::MODE_DOT, 0, 0, 0, 0, 1'b1));
    settle();

    load_regs(-32768, -32768, -32768);
    send_item(mk(cva_pkg::MODE_SCALE, -32768, -32768, 0, 0, 1'b0));
    send_item(mk(cva_pkg::MODE_SCALE, 32767, 1, 0, 0, 1'b0));
    send_item(mk(cva_pkg::MODE_SCALE, -1, 0, 0, 0, 1'b0));
    send_item(mk(cva_pkg::MODE_AXPY, 32767, 32767, -32768, -32768, 1'b0));
    send_item(mk(cva_pkg::MODE_AXPY, -32768, -32768, 32767, -32768, 1'b1));
    send_item(mk(cva_pkg::MODE_AXPY, 0, 0, 0, 0, 1'b0));
    settle();

    load_regs($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
    send_random(190);
    settle();

    send_idle_pct = 48;
    recv_idle_pct = 19;
    load_regs(32767, 32767, 32767);
    send_random(190);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_regs($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
    send_random(190);
    // Two vectors of the largest-magnitude elements, sent back to back.
    send_long(cva_pkg::MODE_NORM, -32768, -32768, 0, 0);
    send_long(cva_pkg::MODE_DOT, -32768, -32768, -32768, 32767);
    in_valid <= 1'b0;

    for (int k = 0; k < 20000 && tracker.owed_results.size() != 0; k++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.owed_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, tracker.owed_results.size());
      tracker.n_errors += tracker.owed_results.size();
    end
    $display("Covered %0d items under five register settings: %0d results checked,",
             tracker.n_items, tracker.n_results);
    $display("  %0d of them reduction sums and %0d clipped.", tracker.n_sums,
             tracker.n_clipped);
    if (tracker.n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
